/* design/mimd_pkg.sv */
// Package: operation codes, widths and pipeline constants for the integer ALU.
package mimd_pkg;
    localparam int DataWidth = 64;
    localparam int WordWidth = 32;
    localparam int OpWidth = 4;
    localparam int ShWidth = 5;
    localparam int DivBitsPerStage = 4;

    typedef enum logic [OpWidth-1:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_ADDU = 4'd2, OP_SUBU = 4'd3,
        OP_OR = 4'd4, OP_XOR = 4'd5, OP_SLT = 4'd6, OP_SLL = 4'd7,
        OP_SRL = 4'd8, OP_SRA = 4'd9, OP_SLLV = 4'd10, OP_SRLV = 4'd11,
        OP_MULT = 4'd12, OP_MULTU = 4'd13, OP_DIV = 4'd14, OP_DIVU = 4'd15
    } t_op;

    typedef struct packed {
        logic [OpWidth-1:0]   req_type;
        logic [DataWidth-1:0] rs_value;
        logic [DataWidth-1:0] rt_value;
        logic [ShWidth-1:0]   shift_amount;
    } t_req;

    typedef struct packed {
        logic [DataWidth-1:0] rd_value;
        logic                 rd_write;
        logic [DataWidth-1:0] lo_value;
        logic [DataWidth-1:0] hi_value;
    } t_rsp;

    function automatic logic [DataWidth-1:0] sext32(input logic [WordWidth-1:0] w);
        return {{(DataWidth-WordWidth){w[WordWidth-1]}}, w};
    endfunction
endpackage

/* design/mimd_if.sv */
// Interfaces: valid/ready channels for request and response beats.
interface mimd_req_if;
    logic              valid;
    logic              ready;
    mimd_pkg::t_req    data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface mimd_rsp_if;
    logic              valid;
    logic              ready;
    mimd_pkg::t_rsp    data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

/* design/mips_integer_alu_muldiv.sv */
// Top level: pipelined MIPS integer ALU with multiply, divide and HI/LO registers.
// Pipeline: 1 decode stage, 8 radix-16 divider stages of 4 quotient bits each, and
//   1 output stage that updates HI/LO.
// Throughput: one beat per cycle; the whole pipe advances when the output is free.
// Reset (synchronous, active low) clears all valid bits and sets LO and HI to zero.
// A stall holds every stage in place; nothing is dropped or repeated.
module mips_integer_alu_muldiv #(
    parameter int DIV_BITS = mimd_pkg::DivBitsPerStage
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mimd_req_if.sink   i_req,
    mimd_rsp_if.source o_rsp
);
    localparam int W = mimd_pkg::WordWidth;
    localparam int D = mimd_pkg::DataWidth;
    localparam int NDS = W / DIV_BITS;
    localparam int NS = NDS + 1;

    typedef struct packed {
        logic [mimd_pkg::OpWidth-1:0] op;
        logic           upd;
        logic           rd_wr;
        logic [D-1:0]   rd;
        logic [W-1:0]   lo;
        logic [W-1:0]   hi;
        logic           is_div;
        logic           special;
        logic           qneg;
        logic           rneg;
        logic [W-1:0]   dvs;
        logic [W-1:0]   rem;
        logic [W-1:0]   quo;
    } t_stg;

    t_stg r_stg [NS];
    logic r_vld [NS];
    t_stg n_stg [NS];
    logic r_ov;
    mimd_pkg::t_rsp r_out;
    logic [D-1:0] r_lo, r_hi;
    logic adv;

    assign adv = !r_ov || o_rsp.ready;
    assign i_req.ready = adv;
    assign o_rsp.valid = r_ov;
    assign o_rsp.data = r_out;

    // Decode stage.
    logic [W-1:0] rsw, rtw, an, ad;
    logic [2*W-1:0] prod;
    logic [D-1:0] rs, rt;
    logic nneg, dneg;
    always_comb begin
        rs = i_req.data.rs_value;
        rt = i_req.data.rt_value;
        rsw = rs[W-1:0];
        rtw = rt[W-1:0];
        nneg = rsw[W-1];
        dneg = rtw[W-1];
        n_stg[0] = '0;
        n_stg[0].op = i_req.data.req_type;
        n_stg[0].rd_wr = 1'b1;
        prod = '0;
        an = nneg ? W'(0 - rsw) : rsw;
        ad = dneg ? W'(0 - rtw) : rtw;
        unique case (mimd_pkg::t_op'(i_req.data.req_type))
            mimd_pkg::OP_ADD, mimd_pkg::OP_ADDU: n_stg[0].rd = mimd_pkg::sext32(rsw + rtw);
            mimd_pkg::OP_SUB, mimd_pkg::OP_SUBU: n_stg[0].rd = mimd_pkg::sext32(rsw - rtw);
            mimd_pkg::OP_OR:  n_stg[0].rd = rs | rt;
            mimd_pkg::OP_XOR: n_stg[0].rd = rs ^ rt;
            mimd_pkg::OP_SLT: n_stg[0].rd = D'($signed(rs) < $signed(rt));
            mimd_pkg::OP_SLL: n_stg[0].rd = mimd_pkg::sext32(rtw << i_req.data.shift_amount);
            mimd_pkg::OP_SRL: n_stg[0].rd = mimd_pkg::sext32(rtw >> i_req.data.shift_amount);
            mimd_pkg::OP_SRA:
                n_stg[0].rd = mimd_pkg::sext32(W'($signed(rtw) >>> i_req.data.shift_amount));
            mimd_pkg::OP_SLLV: n_stg[0].rd = mimd_pkg::sext32(rtw << rs[4:0]);
            mimd_pkg::OP_SRLV: n_stg[0].rd = mimd_pkg::sext32(rtw >> rs[4:0]);
            mimd_pkg::OP_MULT, mimd_pkg::OP_MULTU: begin
                if (i_req.data.req_type == mimd_pkg::OP_MULT)
                    prod = (2*W)'($signed(rsw) * $signed(rtw));
                else
                    prod = rsw * rtw;
                n_stg[0].upd = 1'b1;
                n_stg[0].lo = prod[W-1:0];
                n_stg[0].hi = prod[2*W-1:W];
                n_stg[0].rd = mimd_pkg::sext32(prod[W-1:0]);
            end
            mimd_pkg::OP_DIV: begin
                n_stg[0].upd = 1'b1;
                n_stg[0].rd_wr = 1'b0;
                n_stg[0].is_div = 1'b1;
                if (rsw == 32'h8000_0000 && rtw == 32'hffff_ffff) begin
                    n_stg[0].special = 1'b1;
                    n_stg[0].lo = 32'h8000_0000;
                    n_stg[0].hi = '0;
                end else if (rtw == '0) begin
                    n_stg[0].special = 1'b1;
                    n_stg[0].lo = nneg ? W'(1) : '1;
                    n_stg[0].hi = rsw;
                end
                n_stg[0].qneg = nneg ^ dneg;
                n_stg[0].rneg = nneg;
                n_stg[0].quo = an;
                n_stg[0].dvs = ad;
            end
            mimd_pkg::OP_DIVU: begin
                n_stg[0].upd = 1'b1;
                n_stg[0].rd_wr = 1'b0;
                n_stg[0].is_div = 1'b1;
                if (rtw == '0) begin
                    n_stg[0].special = 1'b1;
                    n_stg[0].lo = '1;
                    n_stg[0].hi = rsw;
                end
                n_stg[0].quo = rsw;
                n_stg[0].dvs = rtw;
            end
            default: n_stg[0].rd = '0;
        endcase
    end

    // Divider stages: restoring, DIV_BITS bits per stage; quo holds dividend shifting out.
    for (genvar s = 1; s < NS; s++) begin : g_div
        always_comb begin
            logic [W:0] tr;
            n_stg[s] = r_stg[s-1];
            for (int b = 0; b < DIV_BITS; b++) begin
                tr = {n_stg[s].rem, n_stg[s].quo[W-1]} - {1'b0, n_stg[s].dvs};
                if (!tr[W]) begin
                    n_stg[s].rem = tr[W-1:0];
                    n_stg[s].quo = {n_stg[s].quo[W-2:0], 1'b1};
                end else begin
                    n_stg[s].rem = {n_stg[s].rem[W-2:0], n_stg[s].quo[W-1]};
                    n_stg[s].quo = {n_stg[s].quo[W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_stg[0] <= n_stg[0];
            for (int s = 1; s < NS; s++) r_stg[s] <= n_stg[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) r_vld[s] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_req.valid;
            for (int s = 1; s < NS; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    // Final stage: resolve divide signs, update HI/LO, register the beat.
    t_stg lst;
    logic [W-1:0] f_lo, f_hi;
    logic [D-1:0] n_lo, n_hi;
    always_comb begin
        lst = r_stg[NS-1];
        if (lst.is_div && !lst.special) begin
            f_lo = lst.qneg ? W'(0 - lst.quo) : lst.quo;
            f_hi = lst.rneg ? W'(0 - lst.rem) : lst.rem;
        end else begin
            f_lo = lst.lo;
            f_hi = lst.hi;
        end
        n_lo = lst.upd ? mimd_pkg::sext32(f_lo) : r_lo;
        n_hi = lst.upd ? mimd_pkg::sext32(f_hi) : r_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_lo <= '0;
            r_hi <= '0;
        end else if (adv) begin
            r_ov <= r_vld[NS-1];
            if (r_vld[NS-1]) begin
                r_lo <= n_lo;
                r_hi <= n_hi;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.rd_value <= lst.rd;
            r_out.rd_write <= lst.rd_wr;
            r_out.lo_value <= n_lo;
            r_out.hi_value <= n_hi;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_rsp.ready) |=> $stable(r_out))
        else $error("output beat changed under stall");
    a_lo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid) |-> (o_rsp.data.lo_value == r_lo && o_rsp.data.hi_value == r_hi))
        else $error("HI/LO mismatch with output beat");
    a_divwr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.data.rd_write) |-> (o_rsp.data.rd_value == '0))
        else $error("divide wrote nonzero rd");
endmodule
